// ===== src/bounded_set_span_tracker_top_defines.svh =====
// ----------------------------------------------------------------------------
// bounded_set_span_tracker_top_defines.svh - assertion macros
// Shared concurrent assertion forms used by the span tracker RTL.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SET_SPAN_TRACKER_TOP_DEFINES_SVH
`define BOUNDED_SET_SPAN_TRACKER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BSST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsst assertion failed");

// next-cycle implication, disabled during reset
`define BSST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsst assertion failed");

`endif

// ===== src/bsst_pkg.sv =====
// ----------------------------------------------------------------------------
// bsst_pkg - span tracker package
// Widths, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsst_pkg;

  localparam int VALUE_W       = 32;
  localparam int COUNT_W       = 11;
  localparam int CAP_W         = 11;
  localparam int MAX_ENTRIES_D = 1024;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  localparam int OUT_DATA_W = 80;  // count + two spans, padded to bytes
  localparam int OUT_USER_W = 2;   // status, span_valid

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic load;     // capture input word, clear scan index
    logic issue;    // read store at scan index
    logic commit;   // write store, update min/max/count
    logic publish;  // load output register
  } cmd_t;

  typedef struct packed {
    logic full;      // held count at effective capacity
    logic empty;     // nothing held
    logic last_idx;  // scan index on last held entry
    logic busy;      // compare pipe still carrying data
    logic out_free;  // output register can take a word
  } stat_t;

endpackage

// ===== src/bounded_set_span_tracker_top.sv =====
// ----------------------------------------------------------------------------
// bounded_set_span_tracker_top - bounded set span tracker
// Result: out_tvalid rises once an accepted word has passed SCAN, DRAIN, COMMIT
//   and RESULT; SCAN and DRAIN are skipped for an empty set or a refused value.
// Flow: the next word is taken only after the controller returns to IDLE; the
//   scan reads one held value per cycle through the single store read port.
// Reset: rst_n sync active low, no word taken; empty set, gap all ones, cap 1024.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Each input word offers a signed value to a set of at most "capacity" values
// (capacity saturates at MAX_ENTRIES). An accepted value is compared against
// every held value, one per cycle, to tighten the smallest gap; then it is
// written to the store and the running min/max and count are updated.
// A refused value leaves the state alone. Every input word yields exactly one
// result word.
//
// Datapath flow for one word:
//   IDLE   -> capture value, latch refused flag
//   SCAN   -> read store[0..n-1], one address per cycle
//   DRAIN  -> let read register and difference register empty
//   COMMIT -> store write at address n, min/max/count update
//   RESULT -> load output register once it is free
// The output register decouples the result side: the next input word is
// taken while the previous result still waits for out_tready.
// The value store has no reset; only entries below the count are read.

module bounded_set_span_tracker_top
  import bsst_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_D  // store depth, 2 .. 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // [31:0] value (signed)
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [10:0] count, [42:11] shortest_span,
                                            // [74:43] longest_span, [79:75] zero
  output logic [OUT_USER_W-1:0] out_tuser,  // [0] status, [1] span_valid
  // capacity register write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CAP_W-1:0]      cfg_data    // [10:0] capacity
);

  cmd_t  cmd;
  stat_t st;

  // capacity writes are taken whenever reset is released
  assign cfg_ready = rst_n;

  bsst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  bsst_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_tdata),
    .cfg_wr     (cfg_valid),
    .cfg_cap    (cfg_data),
    .cmd        (cmd),
    .st         (st),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== src/bsst_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsst_ctrl - span tracker controller
// Sequences accept, store scan, pipe drain, commit and result publish.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsst_ctrl
  import bsst_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // no word taken while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.load = 1'b1;
          // refused or first value: nothing to scan
          state_nxt = (st.full || st.empty) ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (st.last_idx) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!st.busy) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/bsst_dpath.sv =====
// ----------------------------------------------------------------------------
// bsst_dpath - span tracker datapath
// Value store, scan index, gap compare pipe, min/max/count and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bounded_set_span_tracker_top_defines.svh"

module bsst_dpath
  import bsst_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_D
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [VALUE_W-1:0]    in_value,
  input  logic                  cfg_wr,
  input  logic [CAP_W-1:0]      cfg_cap,
  input  cmd_t                  cmd,
  output stat_t                 st,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CW-1:0] HELD_MAX = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] HELD_TWO = CW'(2);
  localparam int PAD_W = OUT_DATA_W - COUNT_W - 2 * VALUE_W;

  // absolute difference of two signed words, exact as unsigned
  function automatic logic [VALUE_W-1:0] abs_diff(input logic [VALUE_W-1:0] a,
                                                  input logic [VALUE_W-1:0] b);
    logic [VALUE_W-1:0] d;
    if ($signed(a) < $signed(b)) begin
      d = b - a;
    end else begin
      d = a - b;
    end
    return d;
  endfunction

  logic [VALUE_W-1:0] store_mem [MAX_ENTRIES];

  logic [CAP_W-1:0]   cap_r;
  logic [CW-1:0]      held_r;
  logic [VALUE_W-1:0] min_r, max_r, gap_r;
  logic [VALUE_W-1:0] value_r;
  logic               reject_r;
  logic [AW-1:0]      idx_r;
  logic [VALUE_W-1:0] rd_data_r;
  logic               rd_vld_r;
  logic [VALUE_W-1:0] diff_r;
  logic               diff_vld_r;

  logic               out_vld_r;
  logic               out_status_r, out_span_vld_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [VALUE_W-1:0] out_short_r, out_long_r;

  logic full, span_ok;

  assign full = (XW'(held_r) >= XW'(cap_r)) || (held_r >= HELD_MAX);
  assign span_ok = (held_r >= HELD_TWO);

  always_comb begin
    st          = '0;
    st.full     = full;
    st.empty    = (held_r == '0);
    st.last_idx = ((CW'(idx_r) + CW'(1)) == held_r);
    st.busy     = rd_vld_r | diff_vld_r;
    st.out_free = !out_vld_r || out_tready;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= cfg_cap;
    end
  end

  // input capture and scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r  <= in_value;
      reject_r <= full;
      idx_r    <= '0;
    end else if (cmd.issue) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  // value store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit && !reject_r) begin
      store_mem[held_r[AW-1:0]] <= value_r;
    end
    if (cmd.issue) begin
      rd_data_r <= store_mem[idx_r];
    end
  end

  // compare pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      diff_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.issue;
      diff_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= abs_diff(value_r, rd_data_r);
  end

  // running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      min_r  <= '0;
      max_r  <= '0;
      gap_r  <= '1;
    end else begin
      if (diff_vld_r && (diff_r < gap_r)) begin
        gap_r <= diff_r;
      end
      if (cmd.commit && !reject_r) begin
        held_r <= held_r + CW'(1);
        if (held_r == '0) begin
          min_r <= value_r;
          max_r <= value_r;
        end else begin
          if ($signed(value_r) < $signed(min_r)) begin
            min_r <= value_r;
          end
          if ($signed(max_r) < $signed(value_r)) begin
            max_r <= value_r;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.publish) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_status_r   <= reject_r ? STATUS_FULL : STATUS_OK;
      out_count_r    <= COUNT_W'(held_r);
      out_span_vld_r <= span_ok;
      out_short_r    <= span_ok ? gap_r : '0;
      out_long_r     <= span_ok ? (max_r - min_r) : '0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_long_r, out_short_r, out_count_r};
  assign out_tuser  = {out_span_vld_r, out_status_r};

  `BSST_ASSERT_NOW(a_held_bound, clk, rst_n, 1'b1, held_r <= HELD_MAX)
  `BSST_ASSERT_NEXT(a_gap_down, clk, rst_n, 1'b1, gap_r <= $past(gap_r))
  `BSST_ASSERT_NOW(a_min_max, clk, rst_n, held_r != '0, $signed(min_r) <= $signed(max_r))
  `BSST_ASSERT_NOW(a_no_overfill, clk, rst_n, cmd.commit && !reject_r, held_r < HELD_MAX)
  `BSST_ASSERT_NOW(a_scan_in_range, clk, rst_n, cmd.issue, CW'(idx_r) < held_r)

endmodule
